>>> rtl/pdsu_pkg.sv
// Shared types, register codes and arithmetic helpers for the PNDM step update.
`default_nettype none

package pdsu_pkg;

    localparam int unsigned TensorDepthDef = 16384;
    localparam int unsigned HistoryDepth   = 4;

    // ceil(2^25 / 3): exact floor(v / 3) for any v below 2^24
    localparam logic [23:0] Div3Mul   = 24'd11184811;
    localparam int unsigned Div3Shift = 25;

    typedef enum logic [1:0] {
        REG_PRK_STEPS,
        REG_SIGMA_CUR_RECIP,
        REG_SIGMA_REF,
        REG_SIGMA_PREV
    } t_cfg_reg;

    typedef enum logic [2:0] {
        DIV_1,
        DIV_2,
        DIV_3,
        DIV_6,
        DIV_12,
        DIV_24
    } t_div;

    typedef struct packed {
        logic       rk;
        logic [1:0] phase;
        logic [2:0] nhist;
        logic [1:0] head;
        logic       pushed;
        logic       last;
    } t_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [19:0] div3(input logic [19:0] v);
        logic [44:0] p;
        p = {25'd0, v} * {21'd0, Div3Mul};
        return p[44:Div3Shift];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pndm_diffusion_step_update.sv
// PNDM step update: ten-stage pipeline with per-element RK and history stores.
`default_nettype none

// One tensor element enters per clock unless the pipe stalls; its result leaves
// from stage ten. A result that waits at the output stalls the whole pipe, input
// included. Without a stall the sustained rate is one element per cycle, set by
// the element stores (accumulator, anchor and four history banks, TENSOR_DEPTH
// words each) that every element reads once on entry; the anchor is written on
// entry, the others in stage eight. When a tensor has fewer than eight elements,
// an element whose store entry is still being updated further down the pipe is
// held at the input until that write lands. The stores are not cleared after
// reset; the first Runge-Kutta quarter tensor writes only its own entries.
module pndm_diffusion_step_update #(
    parameter int unsigned TENSOR_DEPTH = pdsu_pkg::TensorDepthDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] x0_pred, [63:32] sample_in
    input  wire logic        s_axis_tlast,   // last_element
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] prev_sample
    output logic             m_axis_tlast,   // last_out
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata
);
    import pdsu_pkg::*;

    localparam int IDX_W = (TENSOR_DEPTH > 1) ? $clog2(TENSOR_DEPTH) : 1;
    localparam int NST   = 10;

    // configuration
    logic [3:0]         r_prk;
    logic signed [31:0] r_recip, r_sref, r_sprev;
    logic signed [32:0] r_dsig;

    // step control
    logic [3:0]       r_step;
    logic [2:0]       r_fill;
    logic [1:0]       r_head;
    logic [IDX_W-1:0] r_elem_idx;

    // pipeline control
    logic             r_v [1:NST];
    t_ctl             r_c [1:NST];
    logic [IDX_W-1:0] r_i [1:7];

    logic adv, accept, hazard;
    t_ctl in_ctl;
    logic in_last, in_rk;

    // stores
    logic signed [31:0] mem_acc [TENSOR_DEPTH];
    logic signed [31:0] mem_anc [TENSOR_DEPTH];
    logic signed [31:0] r_acc_rd, r_anc_rd;
    logic signed [31:0] r_hist_rd [4];

    // datapath
    logic signed [32:0] r_d1;
    logic signed [31:0] r_smp1;
    logic signed [64:0] r_p2;
    logic signed [31:0] r_base [2:NST-1];
    logic signed [31:0] r_acc [2:7];
    logic signed [31:0] r_h2 [1:3];
    logic signed [31:0] r_h3 [1:3];
    logic signed [31:0] r_eps [3:7];
    logic signed [40:0] r_num4;
    t_div               r_div4;
    logic [35:0]        r_x5, r_x6;
    logic               r_neg5, r_neg6, r_neg7;
    logic               r_pow5, r_pow6;
    logic [17:0]        r_qh6, r_lo6;
    logic [1:0]         r_rh6;
    logic [35:0]        r_q7;
    logic signed [31:0] r_eff8;
    logic signed [64:0] r_p9;
    logic signed [31:0] r_out;

    // combinational stage values
    logic signed [40:0] eps_rnd, e41, h1, h2, h3, num;
    t_div               div_sel;
    logic [40:0]        mag, mag_sum;
    logic [5:0]         half;
    logic [1:0]         shamt;
    logic [17:0]        qh_c;
    logic [19:0]        qh_w, ql_w, v2;
    logic [35:0]        q_c;
    logic signed [41:0] qs42, acc42, accsum;
    logic signed [31:0] acc_new, eff_c;
    logic               acc_we, hist_we;
    logic signed [40:0] out_rnd;

    assign adv           = !r_v[NST] || m_axis_tready;
    assign s_axis_tready = adv && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_v[NST];
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_c[NST].last;

    always_comb begin
        hazard = 1'b0;
        for (int s = 1; s <= 7; s++) begin
            if (r_v[s] && (r_i[s] == r_elem_idx)) begin
                hazard = 1'b1;
            end
        end
    end

    always_comb begin
        in_last         = s_axis_tlast || (r_elem_idx == IDX_W'(TENSOR_DEPTH - 1));
        in_rk           = r_step < r_prk;
        in_ctl.rk       = in_rk;
        in_ctl.phase    = r_step[1:0];
        in_ctl.nhist    = (r_fill >= 3'd3) ? 3'd4 : r_fill + 3'd1;
        in_ctl.head     = r_head;
        in_ctl.pushed   = !in_rk || (r_step[1:0] == 2'd0);
        in_ctl.last     = in_last;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prk   <= 4'd12;
            r_recip <= 32'sd16777216;
            r_sref  <= '0;
            r_sprev <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_PRK_STEPS:       r_prk   <= i_cfg_wdata[3:0];
                REG_SIGMA_CUR_RECIP: r_recip <= i_cfg_wdata;
                REG_SIGMA_REF:       r_sref  <= i_cfg_wdata;
                REG_SIGMA_PREV:      r_sprev <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dsig <= {r_sprev[31], r_sprev} - {r_sref[31], r_sref};
    end

    // per-tensor step control, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= '0;
            r_fill     <= '0;
            r_head     <= '0;
            r_elem_idx <= '0;
        end else if (accept) begin
            if (in_last) begin
                r_elem_idx <= '0;
                if (in_ctl.pushed) begin
                    r_head <= r_head + 2'd1;
                    if (r_fill < 3'd4) begin
                        r_fill <= r_fill + 3'd1;
                    end
                end
                if (in_rk) begin
                    r_step <= r_step + 4'd1;
                end
            end else begin
                r_elem_idx <= r_elem_idx + IDX_W'(1);
            end
        end
    end

    // valid bits and control travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NST; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (adv) begin
            r_v[1] <= accept;
            for (int s = 2; s <= NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c[1] <= in_ctl;
            r_i[1] <= r_elem_idx;
            for (int s = 2; s <= NST; s++) begin
                r_c[s] <= r_c[s-1];
            end
            for (int s = 2; s <= 7; s++) begin
                r_i[s] <= r_i[s-1];
            end
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (accept && in_rk && (r_step[1:0] == 2'd0)) begin
            mem_anc[r_elem_idx] <= s_axis_tdata[63:32];
        end
        if (acc_we) begin
            mem_acc[r_i[7]] <= acc_new;
        end
        if (adv) begin
            r_anc_rd <= mem_anc[r_elem_idx];
            r_acc_rd <= mem_acc[r_elem_idx];
        end
    end

    for (genvar b = 0; b < HistoryDepth; b++) begin : g_hist
        logic signed [31:0] mem_hist [TENSOR_DEPTH];
        always_ff @(posedge i_clk) begin
            if (hist_we && (r_c[7].head == 2'(b))) begin
                mem_hist[r_i[7]] <= r_eps[7];
            end
            if (adv) begin
                r_hist_rd[b] <= mem_hist[r_elem_idx];
            end
        end
    end

    // stage 1: difference
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d1   <= {s_axis_tdata[63], s_axis_tdata[63:32]}
                    - {s_axis_tdata[31], s_axis_tdata[31:0]};
            r_smp1 <= s_axis_tdata[63:32];
        end
    end

    // stage 2: eps product, base and history selection
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2 <= r_d1 * r_recip;
            if (r_c[1].rk && (r_c[1].phase != 2'd0)) begin
                r_base[2] <= r_anc_rd;
            end else begin
                r_base[2] <= r_smp1;
            end
            r_acc[2] <= r_acc_rd;
            for (int k = 1; k <= 3; k++) begin
                r_h2[k] <= r_hist_rd[r_c[1].head - 2'(k)];
            end
        end
    end

    // stage 3: round and saturate eps
    assign eps_rnd = 41'((r_p2 + 65'sd8388608) >>> 24);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eps[3]  <= sat32({eps_rnd[40], eps_rnd});
            r_base[3] <= r_base[2];
            r_acc[3]  <= r_acc[2];
            r_h3      <= r_h2;
        end
    end

    // stage 4: numerator and divisor
    always_comb begin
        e41 = {{9{r_eps[3][31]}}, r_eps[3]};
        h1  = {{9{r_h3[1][31]}}, r_h3[1]};
        h2  = {{9{r_h3[2][31]}}, r_h3[2]};
        h3  = {{9{r_h3[3][31]}}, r_h3[3]};
        num = e41;
        if (r_c[3].rk) begin
            div_sel = ((r_c[3].phase == 2'd1) || (r_c[3].phase == 2'd2)) ? DIV_3 : DIV_6;
        end else begin
            case (r_c[3].nhist)
                3'd1: div_sel = DIV_1;
                3'd2: begin
                    div_sel = DIV_2;
                    num     = 41'sd3 * e41 - h1;
                end
                3'd3: begin
                    div_sel = DIV_12;
                    num     = 41'sd23 * e41 - 41'sd16 * h1 + 41'sd5 * h2;
                end
                default: begin
                    div_sel = DIV_24;
                    num     = 41'sd55 * e41 - 41'sd59 * h1 + 41'sd37 * h2 - 41'sd9 * h3;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_num4    <= num;
            r_div4    <= div_sel;
            r_eps[4]  <= r_eps[3];
            r_base[4] <= r_base[3];
            r_acc[4]  <= r_acc[3];
        end
    end

    // stage 5: magnitude, rounding offset, power-of-two part of the divisor
    always_comb begin
        mag = r_num4[40] ? 41'(-r_num4) : 41'(r_num4);
        case (r_div4)
            DIV_1:   begin half = 6'd0;  shamt = 2'd0; end
            DIV_2:   begin half = 6'd1;  shamt = 2'd1; end
            DIV_3:   begin half = 6'd1;  shamt = 2'd0; end
            DIV_6:   begin half = 6'd3;  shamt = 2'd1; end
            DIV_12:  begin half = 6'd6;  shamt = 2'd2; end
            default: begin half = 6'd12; shamt = 2'd3; end
        endcase
        mag_sum = mag + {35'd0, half};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x5      <= 36'(mag_sum >> shamt);
            r_neg5    <= r_num4[40];
            r_pow5    <= (r_div4 == DIV_1) || (r_div4 == DIV_2);
            r_eps[5]  <= r_eps[4];
            r_base[5] <= r_base[4];
            r_acc[5]  <= r_acc[4];
        end
    end

    // stage 6: divide the upper half by three
    assign qh_w = div3({2'd0, r_x5[35:18]});
    assign qh_c = qh_w[17:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_qh6     <= qh_c;
            r_rh6     <= 2'(r_x5[35:18] - 18'd3 * qh_c);
            r_lo6     <= r_x5[17:0];
            r_x6      <= r_x5;
            r_neg6    <= r_neg5;
            r_pow6    <= r_pow5;
            r_eps[6]  <= r_eps[5];
            r_base[6] <= r_base[5];
            r_acc[6]  <= r_acc[5];
        end
    end

    // stage 7: lower half by three with the carried remainder
    assign v2   = {r_rh6, r_lo6};
    assign ql_w = div3(v2);
    assign q_c  = r_pow6 ? r_x6 : ({r_qh6, 18'd0} + {16'd0, ql_w});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q7      <= q_c;
            r_neg7    <= r_neg6;
            r_eps[7]  <= r_eps[6];
            r_base[7] <= r_base[6];
            r_acc[7]  <= r_acc[6];
        end
    end

    // stage 8: accumulator update, extrapolated eps, store write-back
    always_comb begin
        qs42    = r_neg7 ? -$signed({6'd0, r_q7}) : $signed({6'd0, r_q7});
        acc42   = {{10{r_acc[7][31]}}, r_acc[7]};
        accsum  = acc42 + qs42;
        acc_new = (r_c[7].phase == 2'd0) ? sat32(qs42) : sat32(accsum);
        if (r_c[7].rk) begin
            eff_c = (r_c[7].phase == 2'd3) ? sat32(accsum) : r_eps[7];
        end else begin
            eff_c = sat32(qs42);
        end
        acc_we  = adv && r_v[7] && r_c[7].rk && (r_c[7].phase != 2'd3);
        hist_we = adv && r_v[7] && r_c[7].pushed;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_eff8    <= eff_c;
            r_base[8] <= r_base[7];
        end
    end

    // stage 9: step product
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p9      <= r_dsig * r_eff8;
            r_base[9] <= r_base[8];
        end
    end

    // stage 10: output register
    assign out_rnd = 41'((r_p9 + 65'sd8388608) >>> 24);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= sat32({{10{r_base[9][31]}}, r_base[9]} + {out_rnd[40], out_rnd});
        end
    end

`ifndef SYNTHESIS
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("history fill out of range");

    a_no_rw_clash : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (acc_we || hist_we)) |-> (r_i[7] != r_elem_idx))
        else $error("element read while its write-back is pending");

    a_idx_wrap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && in_last) |=> (r_elem_idx == '0))
        else $error("element index did not restart after tensor end");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST] && !m_axis_tready) |=> (r_v[NST] && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> tb/tb_pndm_diffusion_step_update.sv
// Self-checking testbench for the PNDM step update: stream driver, monitor and predictor.
`default_nettype none

module tb_pndm_diffusion_step_update;
    import pdsu_pkg::*;

    localparam int MaxLen    = 48;
    localparam int DrainWait = 24;
    localparam int StallLim  = 4000;

    typedef struct packed {
        logic [31:0] x0;
        logic [31:0] smp;
        logic        last;
    } t_elem;

    typedef struct packed {
        logic [31:0] prev_sample;
        logic        last_out;
    } t_upd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_wdata = '0;

    pndm_diffusion_step_update u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_elem pending_elems[$];
    t_upd  expected_upds[$];
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    send_hold = 1'b0;
    bit    in_xfer = 1'b0;
    int    n_errors = 0;
    int    n_in = 0;
    int    n_out = 0;
    int    stall_cycles = 0;
    bit    run_done = 1'b0;

    // predictor state
    logic [3:0]  p_prk = 4'd12;
    logic signed [31:0] p_recip = 32'sd16777216;
    logic signed [31:0] p_sref = 0;
    logic signed [31:0] p_sprev = 0;
    int unsigned p_step = 0, p_fill = 0, p_head = 0, p_idx = 0;
    longint p_hist[4][MaxLen];
    longint p_acc[MaxLen];
    longint p_anc[MaxLen];

    // stimulus-side mirror of the control state, keeps every read on written entries
    int unsigned g_prk = 12, g_step = 0, g_fill = 0, g_head = 0;
    int unsigned g_anc_len = 0;
    int unsigned g_hist_len[4] = '{0, 0, 0, 0};
    int unsigned g_queued = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q24_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic longint div_near(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (mag + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint hist_back(input int unsigned back, input int unsigned idx);
        return p_hist[(p_head + 4 - back) % 4][idx];
    endfunction

    function automatic t_upd predict_update(input t_elem e);
        t_upd r;
        longint x0, smp, eps, eff, base;
        int unsigned idx, n;
        bit last, pushed, rk;
        x0 = longint'($signed(e.x0));
        smp = longint'($signed(e.smp));
        idx = p_idx;
        last = e.last || (idx >= TensorDepthDef - 1);
        eps = clip32(q24_mul(smp - x0, longint'(p_recip)));
        pushed = 1'b0;
        rk = p_step < p_prk;
        if (rk) begin
            case (p_step & 3)
                0: begin
                    p_acc[idx] = clip32(div_near(eps, 6));
                    p_hist[p_head][idx] = eps;
                    p_anc[idx] = smp;
                    pushed = 1'b1;
                    eff = eps;
                end
                3: eff = clip32(p_acc[idx] + div_near(eps, 6));
                default: begin
                    p_acc[idx] = clip32(p_acc[idx] + div_near(eps, 3));
                    eff = eps;
                end
            endcase
            base = p_anc[idx];
        end else begin
            n = (p_fill + 1 > 4) ? 4 : p_fill + 1;
            p_hist[p_head][idx] = eps;
            pushed = 1'b1;
            case (n)
                1: eff = eps;
                2: eff = clip32(div_near(3 * eps - hist_back(1, idx), 2));
                3: eff = clip32(div_near(23 * eps - 16 * hist_back(1, idx)
                                         + 5 * hist_back(2, idx), 12));
                default: eff = clip32(div_near(55 * eps - 59 * hist_back(1, idx)
                                               + 37 * hist_back(2, idx)
                                               - 9 * hist_back(3, idx), 24));
            endcase
            base = smp;
        end
        r.prev_sample = 32'(clip32(base + q24_mul(longint'(p_sprev) - longint'(p_sref), eff)));
        r.last_out = last;
        if (last) begin
            p_idx = 0;
            if (pushed) begin
                p_head = (p_head + 1) % 4;
                if (p_fill < 4) p_fill++;
            end
            if (rk) p_step = (p_step + 1) & 15;
        end else begin
            p_idx = idx + 1;
        end
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (!s_axis_tvalid || in_xfer) begin
            if (pending_elems.size() > 0 && !send_hold
                    && $urandom_range(99) >= send_idle_pct) begin
                t_elem e;
                e = pending_elems.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {e.smp, e.x0};
                s_axis_tlast  <= e.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_elem e;
        t_upd  want;
        in_xfer <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_PRK_STEPS:       p_prk   <= i_cfg_wdata[3:0];
                REG_SIGMA_CUR_RECIP: p_recip <= i_cfg_wdata;
                REG_SIGMA_REF:       p_sref  <= i_cfg_wdata;
                REG_SIGMA_PREV:      p_sprev <= i_cfg_wdata;
                default: ;
            endcase
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            e.x0 = s_axis_tdata[31:0];
            e.smp = s_axis_tdata[63:32];
            e.last = s_axis_tlast;
            expected_upds.insert(expected_upds.size(), predict_update(e));
            n_in++;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_out++;
            if (expected_upds.size() == 0) begin
                $display("%0t: unexpected transfer, actual prev_sample %h last_out %b",
                         $time, m_axis_tdata, m_axis_tlast);
                n_errors++;
            end else begin
                want = expected_upds.pop_front();
                if (m_axis_tdata !== want.prev_sample) begin
                    $display("%0t: prev_sample expected %h actual %h",
                             $time, want.prev_sample, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last_out) begin
                    $display("%0t: last_out expected %b actual %b",
                             $time, want.last_out, m_axis_tlast);
                    n_errors++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || run_done) begin
            stall_cycles = 0;
        end else if (i_rst_n) begin
            stall_cycles++;
            if (stall_cycles >= StallLim) begin
                $display("%0t: no transfer for %0d cycles", $time, StallLim);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_cfg_reg r, input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = r;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (r == REG_PRK_STEPS) g_prk = v[3:0];
    endtask

    task automatic wait_drained();
        while (pending_elems.size() > 0 || s_axis_tvalid || expected_upds.size() > 0)
            @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_q24();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
        endcase
    endfunction

    // queue one tensor, clamped so no unwritten store entry is read
    task automatic queue_tensor(input int unsigned len, input bit corner);
        int unsigned cap, k, n, s;
        bit rk;
        t_elem e;
        rk = g_step < g_prk;
        cap = MaxLen;
        if (rk && (g_step & 3) != 0) begin
            cap = g_anc_len;
        end else if (!rk) begin
            n = (g_fill + 1 > 4) ? 4 : g_fill + 1;
            for (k = 1; k < n; k++) begin
                s = (g_head + 4 - k) % 4;
                if (g_hist_len[s] < cap) cap = g_hist_len[s];
            end
        end
        if (len > cap) len = cap;
        if (len == 0) return;
        for (k = 0; k < len; k++) begin
            if (corner) begin
                case (k % 4)
                    0: begin e.x0 = 32'h80000000; e.smp = 32'h7fffffff; end
                    1: begin e.x0 = 32'h7fffffff; e.smp = 32'h80000000; end
                    2: begin e.x0 = 32'h00000000; e.smp = 32'hffffffff; end
                    default: begin e.x0 = 32'h01000000; e.smp = 32'h01000000; end
                endcase
            end else begin
                e.x0 = rand_q24();
                e.smp = ($urandom_range(3) == 0) ? e.x0 + $urandom_range(255) - 128
                                                 : rand_q24();
            end
            e.last = (k == len - 1);
            pending_elems.insert(pending_elems.size(), e);
            g_queued++;
        end
        if (!rk || (g_step & 3) == 0) begin
            if (rk && len > g_anc_len) g_anc_len = len;
            if (len > g_hist_len[g_head]) g_hist_len[g_head] = len;
            g_head = (g_head + 1) % 4;
            if (g_fill < 4) g_fill++;
        end
        if (rk) g_step = (g_step + 1) & 15;
    endtask

    initial begin
        int unsigned ph, total, len;
        bit held;
        logic [3:0] prk_plan[6] = '{4'd4, 4'd12, 4'd0, 4'd15, 4'd7, 4'd12};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extreme fields over four quarter tensors, then multistep
        send_idle_pct = 36;
        recv_idle_pct = 62;
        write_reg(REG_PRK_STEPS, 32'd4);
        write_reg(REG_SIGMA_CUR_RECIP, 32'h01000000);
        write_reg(REG_SIGMA_REF, 32'h00400000);
        write_reg(REG_SIGMA_PREV, 32'hff800000);
        for (int t = 0; t < 6; t++) queue_tensor((t < 4) ? 4 : 1, 1'b1);
        wait_drained();

        held = 1'b0;
        for (ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 36 : (ph < 4) ? 62 : 0;
            recv_idle_pct = (ph < 2) ? 62 : (ph < 4) ? 36 : 0;
            write_reg(REG_PRK_STEPS, {28'd0, prk_plan[ph]});
            if (ph == 2) begin
                write_reg(REG_SIGMA_CUR_RECIP, 32'h7fffffff);
                write_reg(REG_SIGMA_REF, 32'h80000000);
                write_reg(REG_SIGMA_PREV, 32'h7fffffff);
            end else if (ph == 3) begin
                write_reg(REG_SIGMA_CUR_RECIP, 32'h80000000);
                write_reg(REG_SIGMA_REF, 32'h7fffffff);
                write_reg(REG_SIGMA_PREV, 32'h80000000);
            end else begin
                write_reg(REG_SIGMA_CUR_RECIP, 32'($signed($urandom_range(1 << 26)) - (1 << 25)));
                write_reg(REG_SIGMA_REF, 32'($signed($urandom_range(1 << 25))));
                write_reg(REG_SIGMA_PREV, 32'($signed($urandom_range(1 << 24))));
            end
            total = 0;
            g_queued = 0;
            while (total < 165) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(MaxLen, 16)
                                               : $urandom_range(9, 1);
                queue_tensor(len, 1'b0);
                total = g_queued;
                if (ph == 1 && total > 80 && !held) begin
                    // send what is queued, then hold the sender until the pipe drains
                    held = 1'b1;
                    while (pending_elems.size() > 0 || s_axis_tvalid) @(negedge i_clk);
                    send_hold = 1'b1;
                    while (expected_upds.size() > 0) @(negedge i_clk);
                    send_hold = 1'b0;
                end
            end
            wait_drained();
        end

        run_done = 1'b1;
        $display("Covered %0d elements / %0d updates over six register settings,",
                 n_in, n_out);
        $display("quarter and multistep phases, short and long tensors, idle mixes.");
        if (n_errors == 0 && expected_upds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/pdsu_pkg.sv
rtl/pndm_diffusion_step_update.sv
tb/tb_pndm_diffusion_step_update.sv
